[design/piecewise_linear_interpolator_core_defines.svh]
// Assertion macros used by the interpolator core.
`ifndef PIECEWISE_LINEAR_INTERPOLATOR_CORE_DEFINES_SVH
`define PIECEWISE_LINEAR_INTERPOLATOR_CORE_DEFINES_SVH

// A condition that must hold at every clock edge out of reset.
`define PLI_ASSERT_ALWAYS(lbl, expr, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (expr)) else $error(msg);

// A condition that must hold in the cycle after its trigger.
`define PLI_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[design/pli_pkg.sv]
// Shared types and constants of the piecewise linear interpolator.
package pli_pkg;

    localparam int DATA_W         = 32;
    localparam int COUNT_W        = 5;
    localparam int INDEX_W        = 4;
    localparam int MAX_POINTS_DEF = 16;
    localparam int DIV_STEPS      = 32;
    localparam int ALU_W          = DATA_W + 1;

    localparam logic ACT_WRITE = 1'b0;
    localparam logic ACT_EVAL  = 1'b1;

    localparam logic ALU_ADD = 1'b0;
    localparam logic ALU_SUB = 1'b1;

    typedef struct packed {
        logic busy;
        logic done;
    } t_div_stat;

endpackage

[design/piecewise_linear_interpolator_core.sv]
// Piecewise linear interpolator top level: sequencer, shared ALU, table and divider.
// A write transaction is taken in IDLE and the next may follow at once. An evaluate
// clamps at the first or the last point, else searches for the segment and then forms
// the span, offset, y difference and product, divides and adds, raising o_out_valid;
// input is taken again once the result is in the output register.
// Synchronous active-low reset clears the sequencer, output valid and point_count (to 1).
`include "piecewise_linear_interpolator_core_defines.svh"

module piecewise_linear_interpolator_core #(
    parameter int MAX_POINTS = pli_pkg::MAX_POINTS_DEF
) (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    input  logic                                    i_cfg_valid,
    output logic                                    o_cfg_ready,
    input  logic [pli_pkg::COUNT_W-1:0]             i_cfg_data,
    input  logic                                    i_in_valid,
    output logic                                    o_in_stall,
    input  logic                                    i_action,
    input  logic [pli_pkg::INDEX_W-1:0]             i_point_index,
    input  logic signed [pli_pkg::DATA_W-1:0]       i_x_value,
    input  logic signed [pli_pkg::DATA_W-1:0]       i_y_value,
    output logic                                    o_out_valid,
    input  logic                                    i_out_stall,
    output logic signed [pli_pkg::DATA_W-1:0]       o_y_result
);

    localparam int AW = $clog2(MAX_POINTS);
    localparam int DW = pli_pkg::DATA_W;

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_FIRST  = 4'd1;
    localparam logic [3:0] S_LAST   = 4'd2;
    localparam logic [3:0] S_SCAN   = 4'd3;
    localparam logic [3:0] S_SPAN   = 4'd4;
    localparam logic [3:0] S_OFS    = 4'd5;
    localparam logic [3:0] S_DY     = 4'd6;
    localparam logic [3:0] S_DYN    = 4'd7;
    localparam logic [3:0] S_MUL    = 4'd8;
    localparam logic [3:0] S_DSTART = 4'd9;
    localparam logic [3:0] S_DWAIT  = 4'd10;
    localparam logic [3:0] S_ADD    = 4'd11;
    localparam logic [3:0] S_FIN    = 4'd12;

    logic [3:0]                  r_state;
    logic [pli_pkg::COUNT_W-1:0] r_point_count;
    logic [AW-1:0]               r_idx;
    logic [AW-1:0]               r_last_idx;
    logic [DW-1:0]               r_q;
    logic [DW-1:0]               r_x1;
    logic [DW-1:0]               r_y1;
    logic [DW-1:0]               r_x2;
    logic [DW-1:0]               r_y2;
    logic [DW-1:0]               r_span;
    logic [DW-1:0]               r_ofs;
    logic [DW-1:0]               r_mag;
    logic                        r_neg;
    logic [2*DW-1:0]             r_prod;
    logic [DW-1:0]               r_res;
    logic                        r_out_valid;
    logic [DW-1:0]               r_y_result;

    logic                        w_accept;
    logic                        w_wr_en;
    logic [AW-1:0]               w_last_idx;
    logic                        w_rd_en;
    logic [AW-1:0]               w_rd_addr;
    logic [DW-1:0]               w_rd_x;
    logic [DW-1:0]               w_rd_y;
    logic                        w_alu_op;
    logic [pli_pkg::ALU_W-1:0]   w_alu_a;
    logic [pli_pkg::ALU_W-1:0]   w_alu_b;
    logic [pli_pkg::ALU_W-1:0]   w_alu_res;
    logic                        w_neg;
    logic                        w_advance;
    logic                        w_div_start;
    pli_pkg::t_div_stat          w_div_stat;
    logic [DW-1:0]               w_quot;
    logic                        w_out_free;

    assign o_cfg_ready = 1'b1;
    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_y_result  = r_y_result;

    assign w_accept   = i_in_valid && !o_in_stall;
    assign w_wr_en    = w_accept && (i_action == pli_pkg::ACT_WRITE)
                        && (32'(i_point_index) < 32'(MAX_POINTS));
    assign w_neg      = w_alu_res[pli_pkg::ALU_W-1];
    assign w_advance  = w_neg && (r_idx != r_last_idx);
    assign w_out_free = !r_out_valid || !i_out_stall;

    // A count of zero acts as one and a count beyond the table saturates.
    always_comb begin
        if (r_point_count == '0) begin
            w_last_idx = '0;
        end else if (32'(r_point_count) > 32'(MAX_POINTS)) begin
            w_last_idx = AW'(MAX_POINTS - 1);
        end else begin
            w_last_idx = AW'(r_point_count - pli_pkg::COUNT_W'(1));
        end
    end

    // Read requests and ALU operands for each step of the sequence.
    always_comb begin
        w_rd_en     = 1'b0;
        w_rd_addr   = '0;
        w_alu_op    = pli_pkg::ALU_SUB;
        w_alu_a     = '0;
        w_alu_b     = '0;
        w_div_start = 1'b0;
        case (r_state)
            S_IDLE: begin
                w_rd_en = w_accept && (i_action == pli_pkg::ACT_EVAL);
            end
            S_FIRST: begin
                w_alu_a   = {w_rd_x[DW-1], w_rd_x};
                w_alu_b   = {r_q[DW-1], r_q};
                w_rd_en   = w_neg;
                w_rd_addr = r_last_idx;
            end
            S_LAST: begin
                w_alu_a   = {r_q[DW-1], r_q};
                w_alu_b   = {w_rd_x[DW-1], w_rd_x};
                w_rd_en   = w_neg;
                w_rd_addr = AW'(1);
            end
            S_SCAN: begin
                w_alu_a   = {w_rd_x[DW-1], w_rd_x};
                w_alu_b   = {r_q[DW-1], r_q};
                w_rd_en   = w_advance;
                w_rd_addr = r_idx + AW'(1);
            end
            S_SPAN: begin
                w_alu_a = {r_x2[DW-1], r_x2};
                w_alu_b = {r_x1[DW-1], r_x1};
            end
            S_OFS: begin
                w_alu_a = {r_q[DW-1], r_q};
                w_alu_b = {r_x1[DW-1], r_x1};
            end
            S_DY: begin
                w_alu_a = {r_y2[DW-1], r_y2};
                w_alu_b = {r_y1[DW-1], r_y1};
            end
            S_DYN: begin
                w_alu_a = {r_y1[DW-1], r_y1};
                w_alu_b = {r_y2[DW-1], r_y2};
            end
            S_DSTART: begin
                w_div_start = 1'b1;
            end
            S_ADD: begin
                w_alu_op = r_neg ? pli_pkg::ALU_SUB : pli_pkg::ALU_ADD;
                w_alu_a  = {r_y1[DW-1], r_y1};
                w_alu_b  = {1'b0, w_quot};
            end
            default: begin
                w_rd_en = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_point_count <= pli_pkg::COUNT_W'(1);
            r_out_valid   <= 1'b0;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                r_point_count <= i_cfg_data;
            end
            if ((r_state == S_FIN) && w_out_free) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (w_accept && (i_action == pli_pkg::ACT_EVAL)) begin
                        r_state <= S_FIRST;
                    end
                end
                S_FIRST:  r_state <= w_neg ? S_LAST : S_FIN;
                S_LAST:   r_state <= w_neg ? S_SCAN : S_FIN;
                S_SCAN:   r_state <= w_advance ? S_SCAN : S_SPAN;
                S_SPAN:   r_state <= S_OFS;
                S_OFS:    r_state <= S_DY;
                S_DY:     r_state <= w_neg ? S_DYN : S_MUL;
                S_DYN:    r_state <= S_MUL;
                S_MUL:    r_state <= S_DSTART;
                S_DSTART: r_state <= S_DWAIT;
                S_DWAIT: begin
                    if (w_div_stat.done) begin
                        r_state <= S_ADD;
                    end
                end
                S_ADD:    r_state <= S_FIN;
                S_FIN: begin
                    if (w_out_free) begin
                        r_state <= S_IDLE;
                    end
                end
                default:  r_state <= S_IDLE;
            endcase
        end
    end

    // Datapath registers.
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                r_q        <= i_x_value;
                r_last_idx <= w_last_idx;
            end
            S_FIRST: begin
                r_x1  <= w_rd_x;
                r_y1  <= w_rd_y;
                r_res <= w_rd_y;
            end
            S_LAST: begin
                r_res <= w_rd_y;
                r_idx <= AW'(1);
            end
            S_SCAN: begin
                if (w_advance) begin
                    r_x1  <= w_rd_x;
                    r_y1  <= w_rd_y;
                    r_idx <= r_idx + AW'(1);
                end else begin
                    r_x2 <= w_rd_x;
                    r_y2 <= w_rd_y;
                end
            end
            S_SPAN:  r_span <= w_alu_res[DW-1:0];
            S_OFS:   r_ofs  <= w_alu_res[DW-1:0];
            S_DY: begin
                r_neg <= w_neg;
                r_mag <= w_alu_res[DW-1:0];
            end
            S_DYN:   r_mag  <= w_alu_res[DW-1:0];
            S_MUL:   r_prod <= r_ofs * r_mag;
            S_ADD:   r_res  <= w_alu_res[DW-1:0];
            S_FIN: begin
                if (w_out_free) begin
                    r_y_result <= r_res;
                end
            end
            default: r_res <= r_res;
        endcase
    end

    pli_table #(
        .MAX_POINTS (MAX_POINTS)
    ) u_table (
        .i_clk     (i_clk),
        .i_wr_en   (w_wr_en),
        .i_wr_addr (AW'(i_point_index)),
        .i_wr_x    (i_x_value),
        .i_wr_y    (i_y_value),
        .i_rd_en   (w_rd_en),
        .i_rd_addr (w_rd_addr),
        .o_rd_x    (w_rd_x),
        .o_rd_y    (w_rd_y)
    );

    pli_alu u_alu (
        .i_op  (w_alu_op),
        .i_a   (w_alu_a),
        .i_b   (w_alu_b),
        .o_res (w_alu_res)
    );

    pli_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (r_prod),
        .i_divisor  (r_span),
        .o_stat     (w_div_stat),
        .o_quot     (w_quot)
    );

    `PLI_ASSERT_ALWAYS(a_div_busy_in_wait, !w_div_stat.busy || (r_state == S_DWAIT), "divider running outside its wait step")
    `PLI_ASSERT_ALWAYS(a_div_done_in_wait, !w_div_stat.done || (r_state == S_DWAIT), "divider finished outside its wait step")
    `PLI_ASSERT_NEXT(a_scan_exit, r_state == S_SCAN, (r_state == S_SCAN) || (r_state == S_SPAN), "search left to an unexpected step")

endmodule

[design/pli_table.sv]
// Breakpoint store: one write port and one registered read port.
module pli_table #(
    parameter int MAX_POINTS = pli_pkg::MAX_POINTS_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_wr_en,
    input  logic [$clog2(MAX_POINTS)-1:0]       i_wr_addr,
    input  logic [pli_pkg::DATA_W-1:0]          i_wr_x,
    input  logic [pli_pkg::DATA_W-1:0]          i_wr_y,
    input  logic                                i_rd_en,
    input  logic [$clog2(MAX_POINTS)-1:0]       i_rd_addr,
    output logic [pli_pkg::DATA_W-1:0]          o_rd_x,
    output logic [pli_pkg::DATA_W-1:0]          o_rd_y
);

    logic [2*pli_pkg::DATA_W-1:0] r_mem [MAX_POINTS];
    logic [2*pli_pkg::DATA_W-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= {i_wr_x, i_wr_y};
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_x = r_rd_data[2*pli_pkg::DATA_W-1:pli_pkg::DATA_W];
    assign o_rd_y = r_rd_data[pli_pkg::DATA_W-1:0];

endmodule

[design/pli_alu.sv]
// Shared adder and subtractor used for every compare and difference and the final sum.
module pli_alu (
    input  logic                        i_op,
    input  logic [pli_pkg::ALU_W-1:0]   i_a,
    input  logic [pli_pkg::ALU_W-1:0]   i_b,
    output logic [pli_pkg::ALU_W-1:0]   o_res
);

    always_comb begin
        case (i_op)
            pli_pkg::ALU_ADD: o_res = i_a + i_b;
            pli_pkg::ALU_SUB: o_res = i_a - i_b;
            default:          o_res = i_a - i_b;
        endcase
    end

endmodule

[design/pli_div.sv]
// Restoring divider: 64-bit dividend by 32-bit divisor, one quotient bit per cycle.
module pli_div (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_start,
    input  logic [2*pli_pkg::DATA_W-1:0]    i_dividend,
    input  logic [pli_pkg::DATA_W-1:0]      i_divisor,
    output pli_pkg::t_div_stat              o_stat,
    output logic [pli_pkg::DATA_W-1:0]      o_quot
);

    localparam int STEP_W = $clog2(pli_pkg::DIV_STEPS);

    logic [STEP_W-1:0]           r_step;
    logic                        r_busy;
    logic                        r_done;
    logic [pli_pkg::DATA_W-1:0]  r_rem;
    logic [pli_pkg::DATA_W-1:0]  r_low;
    logic [pli_pkg::DATA_W-1:0]  r_divisor;
    logic [pli_pkg::DATA_W:0]    w_trial;
    logic [pli_pkg::DATA_W:0]    w_diff;
    logic                        w_fits;

    // The caller guarantees the quotient fits 32 bits, so the upper half of the
    // dividend is already below the divisor and serves as the first remainder.
    assign w_trial = {r_rem, r_low[pli_pkg::DATA_W-1]};
    assign w_diff  = w_trial - {1'b0, r_divisor};
    assign w_fits  = !w_diff[pli_pkg::DATA_W];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_step <= '0;
            end else if (r_busy) begin
                r_step <= r_step + STEP_W'(1);
                if (r_step == STEP_W'(pli_pkg::DIV_STEPS - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem     <= i_dividend[2*pli_pkg::DATA_W-1:pli_pkg::DATA_W];
            r_low     <= i_dividend[pli_pkg::DATA_W-1:0];
            r_divisor <= i_divisor;
        end else if (r_busy) begin
            r_rem <= w_fits ? w_diff[pli_pkg::DATA_W-1:0] : w_trial[pli_pkg::DATA_W-1:0];
            r_low <= {r_low[pli_pkg::DATA_W-2:0], w_fits};
        end
    end

    assign o_stat.busy = r_busy;
    assign o_stat.done = r_done;
    assign o_quot      = r_low;

endmodule

[bench/tb.sv]
// Self-checking testbench for the piecewise linear interpolator core.
`timescale 1ns / 100ps

module tb;

    localparam int DATA_W         = pli_pkg::DATA_W;
    localparam int COUNT_W        = pli_pkg::COUNT_W;
    localparam int INDEX_W        = pli_pkg::INDEX_W;
    localparam int MAX_POINTS_DEF = pli_pkg::MAX_POINTS_DEF;

    localparam int unsigned SETTLE_CYCLES = 64;
    localparam int unsigned DRAIN_LIMIT   = 20000;
    localparam int unsigned ITEM_TARGET   = 450;
    localparam int unsigned N_ROWS        = 19;

    localparam logic signed [DATA_W-1:0] Q_MIN = 32'sh8000_0000;
    localparam logic signed [DATA_W-1:0] Q_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [DATA_W-1:0] Q_ONE = 32'sh0001_0000;

    typedef enum logic [1:0] {ROW_WRITE, ROW_EVAL, ROW_COUNT} t_row_kind;

    typedef struct packed {
        t_row_kind                kind;
        logic [COUNT_W-1:0]       arg;    // entry on a write, point count on a count row
        logic signed [DATA_W-1:0] x;
        logic signed [DATA_W-1:0] y;      // on an evaluate row: the fixed answer, if any
        logic                     fixed;
    } t_bench_row;

    logic                      i_clk = 1'b0;
    logic                      i_rst_n = 1'b0;
    logic                      i_cfg_valid = 1'b0;
    logic                      o_cfg_ready;
    logic [COUNT_W-1:0]        i_cfg_data = '0;
    logic                      i_in_valid = 1'b0;
    logic                      o_in_stall;
    logic                      i_action = pli_pkg::ACT_WRITE;
    logic [INDEX_W-1:0]        i_point_index = '0;
    logic signed [DATA_W-1:0]  i_x_value = '0;
    logic signed [DATA_W-1:0]  i_y_value = '0;
    logic                      o_out_valid;
    logic                      i_out_stall = 1'b0;
    logic signed [DATA_W-1:0]  o_y_result;

    // Mirror of the block's breakpoint table and point count.
    logic signed [DATA_W-1:0]  bp_x [MAX_POINTS_DEF];
    logic signed [DATA_W-1:0]  bp_y [MAX_POINTS_DEF];
    logic [COUNT_W-1:0]        pts_reg;

    logic signed [DATA_W-1:0]  y_pending_q [$];
    logic signed [DATA_W-1:0]  y_want;
    int unsigned               mismatches = 0;
    int unsigned               items_sent = 0;
    int unsigned               send_idle_pct = 0;
    int unsigned               recv_stall_pct = 0;

    t_bench_row directed_rows [N_ROWS] = '{
        '{ROW_WRITE, 5'd0, Q_ONE,          32'sh0005_0000, 1'b0},
        '{ROW_EVAL,  5'd0, Q_MIN,          32'sh0005_0000, 1'b1},
        '{ROW_EVAL,  5'd0, Q_MAX,          32'sh0005_0000, 1'b1},
        '{ROW_COUNT, 5'd0, '0,             '0,             1'b0},
        '{ROW_EVAL,  5'd0, 32'sh0,         32'sh0005_0000, 1'b1},
        '{ROW_WRITE, 5'd0, Q_MIN,          Q_MIN,          1'b0},
        '{ROW_WRITE, 5'd1, 32'sh0,         Q_MAX,          1'b0},
        '{ROW_WRITE, 5'd2, Q_MAX,          Q_MIN,          1'b0},
        '{ROW_COUNT, 5'd3, '0,             '0,             1'b0},
        '{ROW_EVAL,  5'd0, Q_MIN,          Q_MIN,          1'b1},
        '{ROW_EVAL,  5'd0, Q_MAX,          Q_MIN,          1'b1},
        '{ROW_EVAL,  5'd0, 32'sh0,         Q_MAX,          1'b1},
        '{ROW_EVAL,  5'd0, -32'sd1,        '0,             1'b0},
        '{ROW_EVAL,  5'd0, 32'sd1,         '0,             1'b0},
        '{ROW_EVAL,  5'd0, 32'sh4000_0000, '0,             1'b0},
        '{ROW_WRITE, 5'd1, 32'sh6000_0000, 32'sh0010_0000, 1'b0},
        '{ROW_WRITE, 5'd2, 32'sh1000_0000, Q_ONE,          1'b0},
        '{ROW_EVAL,  5'd0, 32'sh0800_0000, '0,             1'b0},
        '{ROW_EVAL,  5'd0, 32'sh2000_0000, Q_ONE,          1'b1}
    };

    logic [COUNT_W-1:0] count_plan [6] = '{5'd16, 5'd31, 5'd0, 5'd2, 5'd1, 5'd3};

    piecewise_linear_interpolator_core dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_data    (i_cfg_data),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_action      (i_action),
        .i_point_index (i_point_index),
        .i_x_value     (i_x_value),
        .i_y_value     (i_y_value),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_y_result    (o_y_result)
    );

    initial begin
        forever begin
            #5 i_clk = ~i_clk;
        end
    end

    task automatic report_mismatch(input string what, input logic signed [DATA_W-1:0] want,
                                   input logic signed [DATA_W-1:0] got);
        $display("mismatch at %0t: %s, want %h got %h", $realtime, what, want, got);
        mismatches++;
    endtask

    function automatic int unsigned points_in_use();
        if (pts_reg == 0) return 1;
        if (pts_reg > MAX_POINTS_DEF) return MAX_POINTS_DEF;
        return pts_reg;
    endfunction

    // Value of the curve at q. The divisor is always positive, because the entry
    // before the one found always has an x below the query, sorted table or not.
    function automatic logic signed [DATA_W-1:0] interp_at(input logic signed [DATA_W-1:0] q);
        int unsigned       n;
        int unsigned       k;
        longint            x1, x2, y1, y2, dy;
        longint unsigned   span, mag, prod, quot;
        logic signed [63:0] r;
        n = points_in_use();
        if (q <= bp_x[0]) return bp_y[0];
        if (q >= bp_x[n-1]) return bp_y[n-1];
        k = 1;
        while (k < n - 1 && bp_x[k] < q) k++;
        x1 = bp_x[k-1];
        x2 = bp_x[k];
        y1 = bp_y[k-1];
        y2 = bp_y[k];
        span = longint'(x2 - x1);
        dy = y2 - y1;
        mag = (dy < 0) ? longint'(-dy) : longint'(dy);
        prod = longint'(longint'(q) - x1) * mag;
        quot = prod / span;
        r = (dy < 0) ? y1 - longint'(quot) : y1 + longint'(quot);
        return r[DATA_W-1:0];
    endfunction

    // Presents one input transaction and updates the mirror once it is taken.
    task automatic push_item(input logic act, input logic [INDEX_W-1:0] idx,
                             input logic signed [DATA_W-1:0] x,
                             input logic signed [DATA_W-1:0] y, input logic fixed);
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid    <= 1'b1;
        i_action      <= act;
        i_point_index <= idx;
        i_x_value     <= x;
        i_y_value     <= y;
        do @(posedge i_clk); while (o_in_stall);
        items_sent++;
        if (act == pli_pkg::ACT_WRITE) begin
            bp_x[idx] = x;
            bp_y[idx] = y;
        end else begin
            y_pending_q.insert(y_pending_q.size(), fixed ? y : interp_at(x));
        end
    endtask

    // Waits for pending results up to a limit, lets the block go quiet, then flags any unanswered.
    task automatic drain_results();
        int unsigned waited;
        i_in_valid <= 1'b0;
        waited = 0;
        while (y_pending_q.size() != 0 && waited < DRAIN_LIMIT) begin
            @(posedge i_clk);
            waited++;
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        while (y_pending_q.size() != 0)
            report_mismatch("evaluate never answered", y_pending_q.pop_front(), 'x);
    endtask

    task automatic write_count(input logic [COUNT_W-1:0] value);
        drain_results();
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        pts_reg = value;
    endtask

    // One phase: new point count, a fresh table, then queries with some stray writes.
    task automatic run_table_phase(input int unsigned ph);
        logic signed [DATA_W-1:0] xs [MAX_POINTS_DEF];
        logic signed [DATA_W-1:0] ys [MAX_POINTS_DEF];
        logic signed [DATA_W-1:0] tmp, q;
        logic [COUNT_W-1:0]       cnt;
        int unsigned              n, style, k, j, off, evals;
        cnt = (ph < 6) ? count_plan[ph] : COUNT_W'($urandom_range(31));
        case (ph % 4)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 68; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 68; end
            default: begin send_idle_pct = 12; recv_stall_pct = 12; end
        endcase
        write_count(cnt);
        n = points_in_use();
        style = $urandom_range(3);
        for (k = 0; k < n; k++) begin
            if (style == 2) begin
                ys[k] = $signed(32'($urandom_range(2097152))) - 32'sd1048576;
                if (k == 0)
                    xs[k] = $signed(32'($urandom_range(2097152))) - 32'sd1048576;
                else
                    xs[k] = xs[k-1] + $signed(32'($urandom_range(1048576)));
            end else begin
                xs[k] = $urandom;
                ys[k] = $urandom;
            end
        end
        // Styles 0 and 1 sort the random x values; style 3 leaves them unsorted.
        if (style < 2) begin
            for (k = 1; k < n; k++) begin
                tmp = xs[k];
                j = k;
                while (j > 0 && xs[j-1] > tmp) begin
                    xs[j] = xs[j-1];
                    j--;
                end
                xs[j] = tmp;
            end
        end
        off = $urandom_range(n - 1);
        for (k = 0; k < n; k++) begin
            j = (k + off) % n;
            push_item(pli_pkg::ACT_WRITE, INDEX_W'(j), xs[j], ys[j], 1'b0);
        end
        evals = $urandom_range(16, 32);
        for (k = 0; k < evals; k++) begin
            j = $urandom_range(n - 1);
            case ($urandom_range(9))
                0, 1, 2: q = $urandom;
                3, 4:    q = xs[j];
                5:       q = xs[j] + 32'sd1;
                6:       q = xs[j] - 32'sd1;
                7:       q = Q_MIN;
                8:       q = Q_MAX;
                default: q = xs[0] + $signed(32'($urandom_range(32'(xs[n-1] - xs[0]))));
            endcase
            if ($urandom_range(19) == 0)
                push_item(pli_pkg::ACT_WRITE, INDEX_W'($urandom_range(15)), $urandom, $urandom,
                          1'b0);
            push_item(pli_pkg::ACT_EVAL, INDEX_W'($urandom_range(15)), q, $urandom, 1'b0);
        end
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (y_pending_q.size() == 0) begin
                report_mismatch("result with no evaluate pending", 'x, o_y_result);
            end else begin
                y_want = y_pending_q.pop_front();
                if (o_y_result !== y_want)
                    report_mismatch("wrong y_result", y_want, o_y_result);
            end
        end
        i_out_stall <= ($urandom_range(99) < recv_stall_pct);
    end

    initial begin
        int unsigned r;
        int unsigned ph;
        for (r = 0; r < MAX_POINTS_DEF; r++) begin
            bp_x[r] = '0;
            bp_y[r] = '0;
        end
        pts_reg = 5'd1;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        for (r = 0; r < N_ROWS; r++) begin
            case (directed_rows[r].kind)
                ROW_WRITE: push_item(pli_pkg::ACT_WRITE, directed_rows[r].arg[INDEX_W-1:0],
                                     directed_rows[r].x, directed_rows[r].y, 1'b0);
                ROW_EVAL:  push_item(pli_pkg::ACT_EVAL, INDEX_W'($urandom_range(15)),
                                     directed_rows[r].x, directed_rows[r].y,
                                     directed_rows[r].fixed);
                default:   write_count(directed_rows[r].arg);
            endcase
        end
        ph = 0;
        while (items_sent < ITEM_TARGET) begin
            run_table_phase(ph);
            ph++;
        end
        drain_results();
        if (mismatches == 0) begin
            $display("[piecewise_linear_interpolator_core] OK");
        end else begin
            $display("[piecewise_linear_interpolator_core] ERROR");
        end
        $finish;
    end

    initial begin
        #5_000_000;
        $display("[piecewise_linear_interpolator_core] ERROR");
        $finish;
    end

endmodule
